[hw/rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define BDQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Types, sizes and ring helpers for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = $clog2(2 * DEPTH);
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OCC_W = 5;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    action_e                   action;
    logic signed [VAL_W-1:0]   push_value;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VAL_W-1:0]   removed_value;
    logic [OCC_W-1:0]          occupancy;
  } out_item_t;

  // (base + off) mod DEPTH, base < DEPTH, off <= DEPTH
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic out_item_t make_result(status_e st, logic signed [VAL_W-1:0] val,
                                            cnt_t cnt);
    out_item_t r;
    r.status        = st;
    r.removed_value = val;
    r.occupancy     = OCC_W'(cnt);
    return r;
  endfunction

endpackage

[hw/rtl/bdq_ram.sv]
// ----------------------------------------------------------------------------
// bdq_ram
// Single-port synchronous RAM, registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int unsigned DEPTH_P = 16,
  parameter int unsigned WIDTH_P = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic                                         re_i,
  input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] addr_i,
  input  logic [WIDTH_P-1:0]                           wdata_i,
  output logic [WIDTH_P-1:0]                           rdata_o
);

  logic [WIDTH_P-1:0] mem_q [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bounded_deque_top.sv]
// ----------------------------------------------------------------------------
// bounded_deque_top
// Bounded double-ended queue of signed 32-bit values kept in a ring RAM.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------
//  in      | in  | in_valid_i / in_ready_o | in_item_i  (action, push_value)
//  out     | out | out_valid_o/ out_ready_i| out_item_o (status, removed_value,
//          |     |                         |             occupancy)
//
//  For a push, and any rejected operation (pop on empty, push on full), the
//  result is registered the cycle after the item is accepted. A successful
//  pop first reads the RAM, then registers the value in S_READ. One item is
//  in flight at a time, as no item is taken in S_READ. A new item is taken
//  once the sequencer is idle and the output register is free or being drained.
//  Reset (rst_ni, async, active low) clears pointers, count, FSM and output
//  valid; RAM contents are never cleared and need no clearing pass.
//
module bounded_deque_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bdq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bdq_pkg::out_item_t out_item_o
);

  // one-hot sequencer
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e             state_q, state_d;
  bdq_pkg::idx_t      front_q, front_d;
  bdq_pkg::cnt_t      count_q, count_d;
  logic               out_valid_q, out_valid_d;
  bdq_pkg::out_item_t out_item_q, out_item_d;

  // RAM port
  logic                             ram_we, ram_re;
  bdq_pkg::idx_t                    ram_addr;
  logic [bdq_pkg::VAL_W-1:0]        ram_wdata, ram_rdata;

  logic accept, is_full, is_empty;
  bdq_pkg::idx_t new_front;

  assign is_full  = (count_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign is_empty = (count_q == '0);
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign new_front  = bdq_pkg::ring_add(front_q, bdq_pkg::CNT_W'(bdq_pkg::DEPTH - 1));

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = front_q;
    ram_wdata   = in_item_i.push_value;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          case (in_item_i.action)
            bdq_pkg::ACT_PUSH_FRONT: begin
              if (is_full) begin
                out_item_d = bdq_pkg::make_result(bdq_pkg::ST_FULL, '0, count_q);
              end else begin
                ram_we     = 1'b1;
                ram_addr   = new_front;
                front_d    = new_front;
                count_d    = count_q + bdq_pkg::cnt_t'(1);
                out_item_d = bdq_pkg::make_result(bdq_pkg::ST_DONE, '0, count_d);
              end
            end
            bdq_pkg::ACT_PUSH_BACK: begin
              if (is_full) begin
                out_item_d = bdq_pkg::make_result(bdq_pkg::ST_FULL, '0, count_q);
              end else begin
                ram_we     = 1'b1;
                ram_addr   = bdq_pkg::ring_add(front_q, count_q);
                count_d    = count_q + bdq_pkg::cnt_t'(1);
                out_item_d = bdq_pkg::make_result(bdq_pkg::ST_DONE, '0, count_d);
              end
            end
            bdq_pkg::ACT_POP_FRONT: begin
              if (is_empty) begin
                out_item_d = bdq_pkg::make_result(bdq_pkg::ST_EMPTY, '0, count_q);
              end else begin
                // value arrives next cycle; result loaded in S_READ
                out_valid_d = 1'b0;
                ram_re      = 1'b1;
                ram_addr    = front_q;
                front_d     = bdq_pkg::ring_add(front_q, bdq_pkg::CNT_W'(1));
                count_d     = count_q - bdq_pkg::cnt_t'(1);
                state_d     = S_READ;
              end
            end
            default: begin // pop back
              if (is_empty) begin
                out_item_d = bdq_pkg::make_result(bdq_pkg::ST_EMPTY, '0, count_q);
              end else begin
                out_valid_d = 1'b0;
                ram_re      = 1'b1;
                ram_addr    = bdq_pkg::ring_add(front_q, count_q - bdq_pkg::cnt_t'(1));
                count_d     = count_q - bdq_pkg::cnt_t'(1);
                state_d     = S_READ;
              end
            end
          endcase
        end
      end
      S_READ: begin
        // output register was free or drained at accept, nothing else loads it here
        out_valid_d = 1'b1;
        out_item_d  = bdq_pkg::make_result(bdq_pkg::ST_DONE, ram_rdata, count_q);
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  bdq_ram #(
    .DEPTH_P (bdq_pkg::DEPTH),
    .WIDTH_P (bdq_pkg::VAL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hw/rtl/bdq_checker.sv]
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks for the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bdq_pkg::out_item_t out_item_o
);

  // a waiting result holds until taken
  `BDQ_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o), "result changed while stalled")

  // no new item while an undrained result sits in the output register
  `BDQ_ASSERT(a_no_overrun, clk_i, rst_ni, in_valid_i && in_ready_o |-> !out_valid_o || out_ready_i, "item accepted over a stalled result")

  // empty pop leaves an empty queue and returns zero
  `BDQ_ASSERT(a_empty_occ, clk_i, rst_ni, out_valid_o && out_item_o.status == bdq_pkg::ST_EMPTY |-> out_item_o.occupancy == '0 && out_item_o.removed_value == '0, "empty result with data")

  // full push reports a full queue
  `BDQ_ASSERT(a_full_occ, clk_i, rst_ni, out_valid_o && out_item_o.status == bdq_pkg::ST_FULL |-> out_item_o.occupancy == bdq_pkg::OCC_W'(bdq_pkg::DEPTH), "full result with wrong occupancy")

  // nothing comes out once reset has been seen at an edge
  `BDQ_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

bind bounded_deque_top bdq_checker u_bdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
